FILE: rtl/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

   // text store geometry
   localparam int TEXT_DEPTH  = 64;
   localparam int ADDR_W      = $clog2(TEXT_DEPTH);
   localparam int ENTRY_W     = 7;
   localparam int RAW_W       = 8;
   localparam int SCROLL_W    = 7;
   localparam int PERIOD_W    = 16;

   // request kinds on req_tuser
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_APPEND  = 2'd1;
   localparam logic [1:0] CMD_REFRESH = 2'd2;

   localparam logic [7:0]          SEG_BLANK    = 8'hFF;
   localparam logic [7:0]          SEG_DOT      = 8'h7F;
   localparam logic [7:0]          DOT_MASK     = 8'h7F;
   localparam logic [7:0]          CHAR_DOT     = 8'h2E;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd180;
   localparam logic [RAW_W-1:0]    SCROLL_MIN_LEN = 8'd8;
   localparam logic [SCROLL_W-1:0] SCROLL_MAX   = 7'd127;

   typedef logic [7:0] seg_type;

   // ASCII to active-low segments, bit 7 is the decimal point
   function automatic seg_type encode_char(input logic [7:0] c);
      seg_type s;
      case (c)
         "0", "O":                 s = 8'hC0;
         "1", "I":                 s = 8'hF9;
         "2":                      s = 8'hA4;
         "3":                      s = 8'hB0;
         "4":                      s = 8'h99;
         "5", "s", "S":            s = 8'h92;
         "6", "g", "G":            s = 8'h82;
         "7":                      s = 8'hF8;
         "8":                      s = 8'h80;
         "9":                      s = 8'h90;
         "a", "A":                 s = 8'h88;
         "b", "B":                 s = 8'h83;
         "C":                      s = 8'hC6;
         "c":                      s = 8'hA7;
         "d", "D":                 s = 8'hA1;
         "e", "E":                 s = 8'h86;
         "f", "F":                 s = 8'h8E;
         "h", "H":                 s = 8'h89;
         "i":                      s = 8'hDF;
         "j", "J":                 s = 8'hF1;
         "l", "L":                 s = 8'hC7;
         "n", "N":                 s = 8'hAB;
         "o":                      s = 8'hA3;
         "p", "P":                 s = 8'h8C;
         "q", "Q":                 s = 8'h98;
         "r", "R":                 s = 8'hAF;
         "t", "T":                 s = 8'h87;
         "u", "U":                 s = 8'hC1;
         "y", "Y":                 s = 8'h91;
         "k", "K", "m", "M", "v", "V",
         "w", "W", "x", "X", "z", "Z",
         "-":                      s = 8'hBF;
         ".":                      s = SEG_DOT;
         " ":                      s = SEG_BLANK;
         "_":                      s = 8'hF7;
         default:                  s = c;   // unknown codes pass through
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/scrolling_seven_segment_driver.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Payload
// req       in   req_tvalid/tready     tdata = char_code, tuser = command
// rsp       out  rsp_tvalid/tready     tdata[0] = serial_bit, tlast = latch_strobe,
//                                      tuser = message_end
// csr       in   csr_we                csr_wdata = scroll_period
//
// Clear and append requests are taken every cycle while req_tready is high.
// A refresh reads the text store (registered read data), then the 16-bit
// word shifts out one bit per accepted rsp beat, so the output shifter
// sets the rate at which refreshes are sustained.
// One refresh may wait in the read stage while the shifter is busy; req_tready
// drops only while that stage is full and cannot move on.
// Synchronous active-high reset; text store contents are not reset.

module scrolling_seven_segment_driver (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,     // [7:0] char_code
   input  wire  [1:0]  req_tuser,     // [1:0] command
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,     // [0] serial_bit, [7:1] zero
   output logic        rsp_tlast,     // latch_strobe
   output logic        rsp_tuser,     // [0] message_end
   input  wire         csr_we,
   input  wire  [15:0] csr_wdata
);

   // ---------------- state ----------------
   logic [ssd_pkg::PERIOD_W-1:0] period_ff;
   logic [ssd_pkg::ENTRY_W-1:0]  entry_ff,  entry_in;
   logic [ssd_pkg::RAW_W-1:0]    raw_ff,    raw_in;
   logic                         dot_open_ff, dot_open_in;
   ssd_pkg::seg_type             last_seg_ff, last_seg_in;   // copy of newest entry as appended
   logic [ssd_pkg::SCROLL_W-1:0] scroll_ff, scroll_in;
   logic [1:0]                   phase_ff,  phase_in;
   logic [ssd_pkg::PERIOD_W-1:0] frame_ff,  frame_in;

   // text store: one write port (appends), one registered read port (refresh)
   ssd_pkg::seg_type             mem [ssd_pkg::TEXT_DEPTH];
   logic                         mem_we;
   logic [ssd_pkg::ADDR_W-1:0]   mem_waddr;
   ssd_pkg::seg_type             mem_wdata;
   logic [ssd_pkg::ADDR_W-1:0]   mem_raddr;
   ssd_pkg::seg_type             rd_ff;

   // read stage: refresh waiting for its store data / the shifter
   logic                         a_valid_ff, a_valid_in;
   logic                         a_blank_ff, a_blank_in;
   logic [3:0]                   a_sel_ff,   a_sel_in;
   logic                         a_wrap_ff,  a_wrap_in;
   logic                         a_move;

   // output shifter
   logic                         sh_valid_ff, sh_valid_in;
   logic [15:0]                  sh_word_ff,  sh_word_in;
   logic [3:0]                   sh_cnt_ff,   sh_cnt_in;
   logic                         sh_wrap_ff,  sh_wrap_in;
   logic                         sh_last;
   logic                         rsp_fire;

   logic                         req_fire;
   logic [ssd_pkg::RAW_W-1:0]    pos;
   logic [ssd_pkg::PERIOD_W-1:0] frame_inc;
   logic [ssd_pkg::RAW_W-1:0]    scroll_end;
   ssd_pkg::seg_type             seg_out;

   // ---------------- handshakes ----------------
   assign sh_last    = (sh_cnt_ff == 4'd15);
   assign rsp_fire   = sh_valid_ff && rsp_tready;
   assign a_move     = a_valid_ff && (!sh_valid_ff || (rsp_fire && sh_last));
   assign req_tready = !a_valid_ff || a_move;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = sh_valid_ff;
   assign rsp_tdata  = {7'd0, sh_word_ff[15]};
   assign rsp_tlast  = sh_last;
   assign rsp_tuser  = sh_wrap_ff && sh_last;

   // ---------------- request decode and state update ----------------
   assign pos        = ssd_pkg::RAW_W'(scroll_ff) + ssd_pkg::RAW_W'(phase_ff);
   assign frame_inc  = frame_ff + 1'b1;
   assign scroll_end = ssd_pkg::RAW_W'(scroll_ff) + 8'd6;
   assign mem_raddr  = pos[ssd_pkg::ADDR_W-1:0];

   always_comb begin
      entry_in    = entry_ff;
      raw_in      = raw_ff;
      dot_open_in = dot_open_ff;
      last_seg_in = last_seg_ff;
      scroll_in   = scroll_ff;
      phase_in    = phase_ff;
      frame_in    = frame_ff;
      mem_we      = 1'b0;
      mem_waddr   = entry_ff[ssd_pkg::ADDR_W-1:0];
      mem_wdata   = ssd_pkg::encode_char(req_tdata);
      a_blank_in  = a_blank_ff;
      a_sel_in    = a_sel_ff;
      a_wrap_in   = a_wrap_ff;
      a_valid_in  = a_valid_ff && !a_move;

      if (req_fire) begin
         unique case (req_tuser)
            ssd_pkg::CMD_CLEAR: begin
               entry_in    = '0;
               raw_in      = '0;
               dot_open_in = 1'b0;
               scroll_in   = '0;
               frame_in    = '0;
            end
            ssd_pkg::CMD_APPEND: begin
               if (req_tdata == ssd_pkg::CHAR_DOT && dot_open_ff && entry_ff != '0) begin
                  // dot merges into the newest entry
                  mem_we      = 1'b1;
                  mem_waddr   = ssd_pkg::ADDR_W'(entry_ff - 1'b1);
                  mem_wdata   = last_seg_ff & ssd_pkg::DOT_MASK;
                  dot_open_in = 1'b0;
                  raw_in      = raw_ff + 1'b1;
               end else if (entry_ff < ssd_pkg::ENTRY_W'(ssd_pkg::TEXT_DEPTH)) begin
                  mem_we      = 1'b1;
                  entry_in    = entry_ff + 1'b1;
                  raw_in      = raw_ff + 1'b1;
                  dot_open_in = 1'b1;
                  last_seg_in = mem_wdata;
               end
            end
            ssd_pkg::CMD_REFRESH: begin
               a_valid_in = 1'b1;
               a_blank_in = !(pos < ssd_pkg::RAW_W'(entry_ff));
               a_sel_in   = 4'b1000 >> phase_ff;
               a_wrap_in  = 1'b0;
               phase_in   = phase_ff + 1'b1;
               if (phase_ff == 2'd3 && raw_ff > ssd_pkg::SCROLL_MIN_LEN) begin
                  frame_in = frame_inc;
                  if (frame_inc >= period_ff) begin
                     frame_in = '0;
                     if (scroll_end >= raw_ff || scroll_ff >= ssd_pkg::SCROLL_MAX) begin
                        scroll_in = '0;
                        a_wrap_in = 1'b1;
                     end else begin
                        scroll_in = scroll_ff + 1'b1;
                     end
                  end
               end
            end
            default: ;   // unused code: no effect
         endcase
      end
   end

   // ---------------- shifter ----------------
   assign seg_out = a_blank_ff ? ssd_pkg::SEG_BLANK : rd_ff;

   always_comb begin
      sh_valid_in = sh_valid_ff;
      sh_word_in  = sh_word_ff;
      sh_cnt_in   = sh_cnt_ff;
      sh_wrap_in  = sh_wrap_ff;
      if (a_move) begin
         sh_valid_in = 1'b1;
         sh_word_in  = {seg_out, 4'd0, a_sel_ff};
         sh_cnt_in   = '0;
         sh_wrap_in  = a_wrap_ff;
      end else if (rsp_fire) begin
         if (sh_last) begin
            sh_valid_in = 1'b0;
            sh_cnt_in   = '0;
         end else begin
            sh_word_in  = {sh_word_ff[14:0], 1'b0};
            sh_cnt_in   = sh_cnt_ff + 1'b1;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire && req_tuser == ssd_pkg::CMD_REFRESH) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= ssd_pkg::PERIOD_RESET;
         entry_ff    <= '0;
         raw_ff      <= '0;
         dot_open_ff <= 1'b0;
         scroll_ff   <= '0;
         phase_ff    <= '0;
         frame_ff    <= '0;
         a_valid_ff  <= 1'b0;
         sh_valid_ff <= 1'b0;
         sh_cnt_ff   <= '0;
      end else begin
         if (csr_we) begin
            period_ff <= csr_wdata;
         end
         entry_ff    <= entry_in;
         raw_ff      <= raw_in;
         dot_open_ff <= dot_open_in;
         scroll_ff   <= scroll_in;
         phase_ff    <= phase_in;
         frame_ff    <= frame_in;
         a_valid_ff  <= a_valid_in;
         sh_valid_ff <= sh_valid_in;
         sh_cnt_ff   <= sh_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      last_seg_ff <= last_seg_in;
      a_blank_ff  <= a_blank_in;
      a_sel_ff    <= a_sel_in;
      a_wrap_ff   <= a_wrap_in;
      sh_word_ff  <= sh_word_in;
      sh_wrap_ff  <= sh_wrap_in;
   end

   // ---------------- assertions ----------------
   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      entry_ff <= ssd_pkg::ENTRY_W'(ssd_pkg::TEXT_DEPTH))
      else $error("entry count past store depth");

   a_dot_has_entry: assert property (@(posedge clock) disable iff (reset)
      dot_open_ff |-> entry_ff != '0)
      else $error("open dot with empty text");

   a_refresh_staged: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == ssd_pkg::CMD_REFRESH) |=> a_valid_ff)
      else $error("refresh request lost before read stage");

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !sh_valid_ff |-> sh_cnt_ff == '0)
      else $error("bit counter running with shifter empty");

   a_load_on_last: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && rsp_fire && sh_last) |=> (sh_valid_ff && sh_cnt_ff == '0))
      else $error("staged refresh not loaded after latch beat");

endmodule

`default_nettype wire
